// ===== sv/carrot_path_follower_core_assert.svh =====
// Assertion macros for the path follower core
`ifndef CARROT_PATH_FOLLOWER_CORE_ASSERT_SVH
`define CARROT_PATH_FOLLOWER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define CPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle
`define CPF_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/cpf_pkg.sv =====
package cpf_pkg;

  localparam int unsigned PathDepth  = 256;
  localparam int unsigned PtrW       = $clog2(PathDepth);
  localparam int unsigned CntW       = PtrW + 1;
  localparam int unsigned AngleIters = 16;
  localparam int unsigned IterW      = $clog2(AngleIters);
  // CORDIC datapath: 25-bit offset times 256, plus growth
  localparam int unsigned CordW      = 36;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdPos    = 2'd2;

  localparam logic [1:0] RegNavEn  = 2'd0;
  localparam logic [1:0] RegLook   = 2'd1;
  localparam logic [1:0] RegCruise = 2'd2;
  localparam logic [1:0] RegGain   = 2'd3;

  typedef struct packed {
    logic        nav_enable;
    logic [15:0] lookahead_dist;
    logic [6:0]  cruise_pwm;
    logic [9:0]  steer_gain;
  } cfg_t;

  // Arctangent table in 65536-per-turn units
  function automatic logic [15:0] atan_lut(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'd8192;
      5'd1:  r = 16'd4836;
      5'd2:  r = 16'd2555;
      5'd3:  r = 16'd1297;
      5'd4:  r = 16'd651;
      5'd5:  r = 16'd326;
      5'd6:  r = 16'd163;
      5'd7:  r = 16'd81;
      5'd8:  r = 16'd41;
      5'd9:  r = 16'd20;
      5'd10: r = 16'd10;
      5'd11: r = 16'd5;
      5'd12: r = 16'd3;
      5'd13: r = 16'd1;
      5'd14: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

// ===== sv/cpf_ram.sv =====
module cpf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write one word, read registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/cpf_cordic.sv =====
module cpf_cordic import cpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] dx_i,
  input  logic signed [24:0] dy_i,
  output logic               done_o,
  output logic [15:0]        angle_o
);
  logic signed [CordW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic [15:0] z_q, z_d;
  logic [IterW-1:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [CordW-1:0] x0, y0;

  assign x0 = {{(CordW-33){dx_i[24]}}, dx_i, 8'd0};
  assign y0 = {{(CordW-33){dy_i[24]}}, dy_i, 8'd0};
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  // Rotate one step per cycle
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; it_d = '0;
      if (dx_i < 0) begin
        x_d = -x0; y_d = -y0; z_d = 16'h8000;
      end else begin
        x_d = x0; y_d = y0; z_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[CordW-1]) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atan_lut(5'(it_q));
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atan_lut(5'(it_q));
      end
      it_d = it_q + 1'b1;
      if (it_q == IterW'(AngleIters - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; it_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;
endmodule

// ===== sv/carrot_path_follower_core.sv =====
// Follow-the-carrot path tracker with serial motor frames.
// Input channel (in_valid_i / in_stall_o) carries cmd, pos_x, pos_y, heading.
// Clear and append are absorbed in the cycle they are taken; the block stays idle.
// A position item, when enabled and the ring is not empty, examines head
// waypoints one by one, each through store read, offset and squared-distance
// compare, popping those closer than the lookahead radius. Unless the offset
// is zero it then runs a 16-step CORDIC arctangent; a steer multiply follows.
// A ring emptied by popping skips the angle and the multiply.
// Results: ten bytes on out_valid_o / out_stall_i, one per cycle while the
// receiver does not stall; last_byte_o marks the tenth. A stalled byte holds.
// The next input item is taken once all ten bytes have gone.
// Configuration is to be written through the APB port while idle; the block does not enforce it.
// Reset empties the ring, restores register defaults and clears last steer;
// the waypoint memories keep their contents and need no clearing pass.
module carrot_path_follower_core import cpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [15:0]        heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic               last_byte_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
`include "carrot_path_follower_core_assert.svh"

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StDist  = 7'b0000100,
    StCmp   = 7'b0001000,
    StAngle = 7'b0010000,
    StMul   = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cfg_t cfg_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0] last_q, last_d;
  logic signed [23:0] px_q, py_q;
  logic [15:0] hd_q;
  logic [3:0] bidx_q, bidx_d;
  logic signed [7:0] steer_q, steer_d;
  logic [6:0] speed_q, speed_d;
  logic signed [24:0] dx_q, dy_q, dx_d, dy_d;
  logic [49:0] dxx_q, dyy_q;
  logic [31:0] reach_q;
  logic [25:0] prod;
  logic [15:0] absang_q;
  logic sign_q, zero_q;
  logic in_acc, out_acc, wr_en;
  logic [23:0] rx, ry;
  logic cstart, cdone;
  logic [15:0] cang, err;

  assign pready = 1'b1;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  // Register write and read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{nav_enable: 1'b0, lookahead_dist: 16'd256, cruise_pwm: 7'd42,
                 steer_gain: 10'd120};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegNavEn:  cfg_q.nav_enable     <= pwdata[0];
        RegLook:   cfg_q.lookahead_dist <= pwdata[15:0];
        RegCruise: cfg_q.cruise_pwm     <= pwdata[6:0];
        RegGain:   cfg_q.steer_gain     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegNavEn:  prdata = {31'd0, cfg_q.nav_enable};
      RegLook:   prdata = {16'd0, cfg_q.lookahead_dist};
      RegCruise: prdata = {25'd0, cfg_q.cruise_pwm};
      RegGain:   prdata = {22'd0, cfg_q.steer_gain};
      default:   prdata = '0;
    endcase
  end

  // Waypoint stores; read ahead at the next head so the word is ready in StRead
  assign wr_en = in_acc && cmd_i == CmdAppend && cnt_q < CntW'(PathDepth);
  cpf_ram #(.Width(24), .Depth(PathDepth)) u_ram_x (
    .clk_i, .we_i(wr_en), .waddr_i(PtrW'(head_q + cnt_q[PtrW-1:0])),
    .wdata_i(pos_x_i), .raddr_i(head_d), .rdata_o(rx));
  cpf_ram #(.Width(24), .Depth(PathDepth)) u_ram_y (
    .clk_i, .we_i(wr_en), .waddr_i(PtrW'(head_q + cnt_q[PtrW-1:0])),
    .wdata_i(pos_y_i), .raddr_i(head_d), .rdata_o(ry));

  assign cstart = (state_q == StCmp) && !((dxx_q + dyy_q) < 50'(reach_q))
                  && !(dx_q == '0 && dy_q == '0);
  cpf_cordic u_cordic (.clk_i, .rst_ni, .start_i(cstart), .dx_i(dx_q), .dy_i(dy_q),
                       .done_o(cdone), .angle_o(cang));
  assign err = cang - hd_q;

  // Sequence the pop loop, angle and frame bytes
  always_comb begin
    state_d = state_q; head_d = head_q; cnt_d = cnt_q; last_d = last_q;
    bidx_d = bidx_q; steer_d = steer_q; speed_d = speed_q;
    dx_d = $signed({rx[23], rx}) - $signed({px_q[23], px_q});
    dy_d = $signed({ry[23], ry}) - $signed({py_q[23], py_q});
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (cmd_i)
            CmdClear: begin head_d = '0; cnt_d = '0; end
            CmdAppend: if (wr_en) cnt_d = cnt_q + 1'b1;
            CmdPos: if (cfg_q.nav_enable && cnt_q != '0) state_d = StRead;
            default: ;
          endcase
        end
      end
      StRead: state_d = StDist;
      StDist: state_d = StCmp;
      StCmp: begin
        if ((dxx_q + dyy_q) < 50'(reach_q)) begin
          head_d = head_q + 1'b1; cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            steer_d = last_q; speed_d = '0; bidx_d = '0; state_d = StEmit;
          end else begin
            state_d = StRead;
          end
        end else if (dx_q == '0 && dy_q == '0) begin
          state_d = StMul;
        end else begin
          state_d = StAngle;
        end
      end
      StAngle: if (cdone) state_d = StMul;
      StMul: begin
        steer_d = (prod[25:16] > 10'd127) ? 8'sd127 : 8'(prod[25:16]);
        if (!sign_q && !zero_q) steer_d = -steer_d;
        if (zero_q) steer_d = 8'sd0;
        last_d = steer_d; speed_d = cfg_q.cruise_pwm; bidx_d = '0; state_d = StEmit;
      end
      StEmit: if (out_acc) begin
        bidx_d = bidx_q + 1'b1;
        if (bidx_q == 4'd9) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Scale the latched error magnitude by the gain
  assign prod = 26'(absang_q) * 26'(cfg_q.steer_gain);

  // Angle error magnitude, offsets and squared distance
  always_ff @(posedge clk_i) begin
    logic [15:0] ang;
    ang = (state_q == StCmp) ? (16'd0 - hd_q) : err;
    if (state_q == StCmp || (state_q == StAngle && cdone)) begin
      sign_q   <= ang[15];
      zero_q   <= (ang == '0);
      absang_q <= ang[15] ? 16'(-ang) : ang;
    end
    if (in_acc) begin px_q <= pos_x_i; py_q <= pos_y_i; hd_q <= heading_i; end
    reach_q <= 32'(cfg_q.lookahead_dist) * 32'(cfg_q.lookahead_dist);
    dx_q <= dx_d; dy_q <= dy_d;
    dxx_q <= 50'(dx_q * dx_q);
    dyy_q <= 50'(dy_q * dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; head_q <= '0; cnt_q <= '0; last_q <= '0;
      bidx_q <= '0; steer_q <= '0; speed_q <= '0;
    end else begin
      state_q <= state_d; head_q <= head_d; cnt_q <= cnt_d; last_q <= last_d;
      bidx_q <= bidx_d; steer_q <= steer_d; speed_q <= speed_d;
    end
  end

  // Pick the frame byte
  logic [7:0] smag;
  assign smag = steer_q[7] ? 8'(-steer_q) : 8'(steer_q);
  always_comb begin
    case (bidx_q)
      4'd0, 4'd5: frame_byte_o = 8'h21;
      4'd1: frame_byte_o = steer_q[7] ? 8'h61 : 8'h41;
      4'd2: frame_byte_o = hex_char(smag[7:4]);
      4'd3: frame_byte_o = hex_char(smag[3:0]);
      4'd6: frame_byte_o = 8'h42;
      4'd7: frame_byte_o = hex_char({1'b0, speed_q[6:4]});
      4'd8: frame_byte_o = hex_char(speed_q[3:0]);
      default: frame_byte_o = 8'h0d;
    endcase
  end
  assign out_valid_o = (state_q == StEmit);
  assign last_byte_o = (bidx_q == 4'd9);

  `CPF_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= CntW'(PathDepth), "count above depth")
  `CPF_ASSERT(a_last_emit, clk_i, rst_ni, !last_byte_o || out_valid_o, "last outside frame")
  `CPF_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(bidx_q), "stalled byte moved")
endmodule

// ===== tb/carrot_path_follower_core_checker.sv =====
module carrot_path_follower_core_checker import cpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         cmd_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [15:0]        heading_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         frame_byte_i,
  input  logic               last_byte_i,
  input  cfg_t               cfg_i,
  output int                 fail_count_o,
  output int                 pending_bytes_o
);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_word_t;

  // Tracker state mirrored from the block
  logic signed [23:0] path_x [PathDepth];
  logic signed [23:0] path_y [PathDepth];
  logic [PtrW-1:0]    path_head;
  logic [CntW-1:0]    path_count;
  logic signed [7:0]  held_steer;
  frame_word_t        frame_queue[$];
  int                 fail_count;

  assign fail_count_o    = fail_count;
  assign pending_bytes_o = frame_queue.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [7:0] to_hex(input logic [3:0] n);
    return (n < 10) ? 8'(48 + n) : 8'(55 + n);
  endfunction

  // Vectoring arctangent, 65536 units per turn
  function automatic logic [15:0] bearing_to(input longint dx, input longint dy);
    longint x, y, xs, ys;
    int z;
    int angles [16];
    angles = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (dx == 0 && dy == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < AngleIters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + angles[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - angles[i];
      end
    end
    return z[15:0];
  endfunction

  task automatic push_frames(input int steer, input int speed);
    logic [7:0] bytes [10];
    int mag;
    frame_word_t word;
    mag = steer < 0 ? -steer : steer;
    bytes = '{8'h21, (steer < 0) ? 8'h61 : 8'h41, to_hex(mag[7:4]), to_hex(mag[3:0]),
              8'd13, 8'h21, 8'h42, to_hex(speed[7:4]), to_hex(speed[3:0]), 8'd13};
    for (int k = 0; k < 10; k++) begin
      word.frame_byte = bytes[k];
      word.last_byte  = (k == 9);
      frame_queue.insert(frame_queue.size(), word);
    end
  endtask

  // Advance the tracker on one accepted word
  task automatic track_word(input logic [1:0] cmd, input logic signed [23:0] px,
                            input logic signed [23:0] py, input logic [15:0] hdg);
    longint dx, dy, reach2, d2;
    logic [15:0] err;
    int es, mag;
    dx = 0;
    dy = 0;
    case (cmd)
      CmdClear: begin
        path_head = '0;
        path_count = '0;
      end
      CmdAppend: begin
        if (path_count < PathDepth) begin
          path_x[PtrW'(path_head + path_count)] = px;
          path_y[PtrW'(path_head + path_count)] = py;
          path_count++;
        end
      end
      CmdPos: begin
        if (cfg_i.nav_enable && path_count != 0) begin
          reach2 = longint'(cfg_i.lookahead_dist) * longint'(cfg_i.lookahead_dist);
          while (path_count > 0) begin
            dx = longint'(path_x[path_head]) - longint'(px);
            dy = longint'(path_y[path_head]) - longint'(py);
            d2 = dx * dx + dy * dy;
            if (d2 < reach2) begin
              path_head++;
              path_count--;
            end else break;
          end
          if (path_count == 0) push_frames(held_steer, 0);
          else begin
            err = bearing_to(dx, dy) - hdg;
            es = int'($signed(err));
            mag = ((es < 0 ? -es : es) * int'(cfg_i.steer_gain)) >>> 16;
            if (mag > 127) mag = 127;
            held_steer = (es > 0) ? -mag : mag;
            push_frames(held_steer, cfg_i.cruise_pwm);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Watch both channels and compare
  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t want;
    if (!rst_ni) begin
      path_head  = '0;
      path_count = '0;
      held_steer = '0;
      fail_count = 0;
      frame_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_queue.size() == 0) report_mismatch("byte with none expected");
        else begin
          want = frame_queue.pop_front();
          if (frame_byte_i !== want.frame_byte)
            report_mismatch($sformatf("frame_byte %h want %h", frame_byte_i,
                                      want.frame_byte));
          if (last_byte_i !== want.last_byte)
            report_mismatch($sformatf("last_byte %b want %b", last_byte_i,
                                      want.last_byte));
        end
      end
      if (in_valid_i && !in_stall_i) track_word(cmd_i, pos_x_i, pos_y_i, heading_i);
    end
  end

endmodule

// ===== tb/carrot_path_follower_core_tb.sv =====
module carrot_path_follower_core_tb;
  import cpf_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic signed [23:0] pos_x_i;
  logic signed [23:0] pos_y_i;
  logic [15:0]        heading_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         frame_byte_o;
  logic               last_byte_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  cfg_t cfg;
  int   fail_count;
  int   pending_bytes;
  bit   calm;
  logic signed [23:0] walk_x, walk_y;

  carrot_path_follower_core u_dut (.*);

  carrot_path_follower_core_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .pos_x_i, .pos_y_i,
    .heading_i, .out_valid_i(out_valid_o), .out_stall_i, .frame_byte_i(frame_byte_o),
    .last_byte_i(last_byte_o), .cfg_i(cfg), .fail_count_o(fail_count),
    .pending_bytes_o(pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("carrot_path_follower_core_tb: errors");
    $finish;
  end

  // Random stall on the result side
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 19);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid_i <= 1'b0;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegNavEn:  cfg.nav_enable     = val[0];
      RegLook:   cfg.lookahead_dist = val[15:0];
      RegCruise: cfg.cruise_pwm     = val[6:0];
      default:   cfg.steer_gain     = val[9:0];
    endcase
  endtask

  // Drop valid, drain all frames, then let the block settle
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic signed [23:0] x,
                           input logic signed [23:0] y, input logic [15:0] hdg);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    pos_x_i    <= x;
    pos_y_i    <= y;
    heading_i  <= hdg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rand24();
    return 24'($urandom);
  endfunction

  initial begin
    int n;
    logic [1:0] c;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cmd_i = CmdClear;
    pos_x_i = '0;
    pos_y_i = '0;
    heading_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg = '{1'b0, 16'd256, 7'd42, 10'd120};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled: position words give nothing
    send_word(CmdAppend, 24'sd1000, 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(2'd3, 24'sd5, 24'sd5, 16'd5);
    drain_frames();
    write_reg(RegNavEn, 32'hFFFF_FFFF);
    write_reg(RegGain, 32'd1023);
    write_reg(RegCruise, 32'd127);

    // Directed: extremes, left and right error, popping to empty
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd16384);
    send_word(CmdAppend, -24'sd8388608, 24'sd8388607, 16'd0);
    send_word(CmdPos, 24'sd8388607, -24'sd8388608, 16'hFFFF);
    send_word(CmdAppend, 24'sd0, -24'sd300, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd100);
    send_word(CmdClear, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdAppend, 24'sd10, 24'sd10, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    drain_frames();
    write_reg(RegLook, 32'd0);
    send_word(CmdAppend, 24'sd7, 24'sd7, 16'd0);
    send_word(CmdPos, 24'sd7, 24'sd7, 16'd32768);
    drain_frames();
    write_reg(RegLook, 32'd65535);
    write_reg(RegCruise, 32'd0);
    write_reg(RegGain, 32'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdAppend, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdPos, -24'sd8388608, -24'sd8388608, 16'd0);
    // Fill the ring past full, then pop through it
    send_word(CmdClear, 24'sd0, 24'sd0, 16'd0);
    for (int i = 0; i < PathDepth + 3; i++) send_word(CmdAppend, 24'(i * 64), 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd0, 24'sd0, 16'd0);
    send_word(CmdPos, 24'sd2000000, 24'sd0, 16'd0);
    drain_frames();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegNavEn, (ph != 2));
      write_reg(RegLook, (ph == 5) ? $urandom_range(65535) : $urandom_range(2000));
      write_reg(RegCruise, $urandom_range(127));
      write_reg(RegGain, (ph == 1) ? 32'd1023 : $urandom_range(1023));
      calm = (ph == 3);
      walk_x = rand24();
      walk_y = rand24();
      for (n = 0; n < 33; n++) begin
        if (n == 16) drain_frames();
        if ($urandom_range(9) < 8) begin
          // Path-like walk: waypoints near the robot
          c = ($urandom_range(2) == 0) ? CmdAppend : CmdPos;
          if ($urandom_range(30) == 0) c = CmdClear;
          walk_x = walk_x + 24'($signed($urandom_range(1200)) - 600);
          walk_y = walk_y + 24'($signed($urandom_range(1200)) - 600);
          send_word(c, walk_x, walk_y, 16'($urandom));
        end else begin
          send_word(2'($urandom), rand24(), rand24(), 16'($urandom));
        end
      end
      drain_frames();
    end
    calm = 1'b0;

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("carrot_path_follower_core_tb: clean");
    end else begin
      $display("carrot_path_follower_core_tb: errors");
    end
    $finish;
  end

endmodule
